FILE: design/fppl_pkg.sv
// ----------------------------------------------------------------------------
// fppl_pkg - shared types and constants of the filtered proportional pwm loop
// register indexes, sequencer states, fixed field widths
// ----------------------------------------------------------------------------
package fppl_pkg;

  localparam int unsigned REG_W      = 10;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned GAIN_FRAC  = 8;
  localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

  localparam logic [REG_W-1:0] SETPOINT_RST  = 10'd310;
  localparam logic [REG_W-1:0] GAIN_RST      = 10'd128;
  localparam logic [REG_W-1:0] THRESHOLD_RST = 10'd3;
  localparam logic [REG_W-1:0] MAX_STEP_RST  = 10'd50;
  localparam logic [REG_W-1:0] PWM_TOP_RST   = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_GAIN      = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_MAX_STEP  = 3'd3,
    CFG_PWM_TOP   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_LVL_DIV,
    ST_LVL_WAIT,
    ST_MUL,
    ST_STEP,
    ST_DUTY_DIV,
    ST_DUTY_WAIT,
    ST_DONE
  } fppl_state_e;

  // ring access strobes from the sequencer
  typedef struct packed {
    logic rd;
    logic wr;
  } avg_ctrl_t;

endpackage

FILE: design/filtered_proportional_pwm_loop.sv
// ----------------------------------------------------------------------------
// filtered_proportional_pwm_loop - moving average proportional pwm controller
// averages adc samples, steps the pwm compare value toward the setpoint
// ----------------------------------------------------------------------------
// The divider width D is the larger of SAMPLE_BITS + log2(AVERAGE_DEPTH) and
// 17. A single shared bit-serial divider runs twice per item: once for the
// average (sum over sample count) and once for the duty percent. The input is
// ready only while the sequencer is idle; a finished result moves to the output
// register only once that register is free, and until then the sequencer waits
// in its done state and holds off the next sample. The sample ring needs no
// clearing pass after reset: entries are read as zero until the ring has filled.
module filtered_proportional_pwm_loop #(
  parameter int unsigned AVERAGE_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS   = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fppl_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [fppl_pkg::REG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [SAMPLE_BITS-1:0]             adc_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fppl_pkg::REG_W-1:0]         filtered_level_o,
  output logic                               adjusted_o,
  output logic [fppl_pkg::REG_W-1:0]         pwm_compare_o,
  output logic [fppl_pkg::DUTY_W-1:0]        duty_pct_o
);
  import fppl_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(AVERAGE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(AVERAGE_DEPTH + 1);
  localparam int unsigned MUL_W  = REG_W + DUTY_W;
  localparam int unsigned DVD_W  = (SUM_W > MUL_W) ? SUM_W : MUL_W;
  localparam int unsigned DVS_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int unsigned CMP_W  = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
  localparam int unsigned PROD_W = CMP_W + REG_W;
  localparam int unsigned STEP_W = PROD_W - GAIN_FRAC;

  // configuration
  logic [REG_W-1:0] setpoint_q, gain_q, thr_q, max_step_q, top_q;

  // sequencer and datapath
  fppl_state_e       state_q, state_d;
  avg_ctrl_t         avg_ctrl;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [SUM_W-1:0]  avg_sum;
  logic [CNT_W-1:0]  avg_fill;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] level_q;
  logic [REG_W-1:0]       acc_q;
  logic [REG_W-1:0]       cmp_q;
  logic                   adjust_q;
  logic                   neg_q;
  logic [PROD_W-1:0]      prod_q;
  logic [DUTY_W-1:0]      duty_q;

  logic                   out_valid_q;
  logic [REG_W-1:0]       filtered_level_q;
  logic                   adjusted_q;
  logic [REG_W-1:0]       pwm_compare_q;
  logic [DUTY_W-1:0]      duty_pct_q;

  logic                   accept;
  logic                   out_free;
  logic [CMP_W-1:0]       level_x, acc_x, set_x;
  logic [CMP_W-1:0]       gap, err;
  logic [PROD_W-1:0]      prod_d;
  logic [STEP_W-1:0]      step_raw;
  logic [REG_W-1:0]       step_lim;
  logic [REG_W:0]         cmp_up, cmp_tmp;
  logic [REG_W-1:0]       cmp_dn, cmp_next;
  logic [MUL_W-1:0]       duty_prod;
  logic [DUTY_W-1:0]      duty_d;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RST;
      gain_q     <= GAIN_RST;
      thr_q      <= THRESHOLD_RST;
      max_step_q <= MAX_STEP_RST;
      top_q      <= PWM_TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SETPOINT:  setpoint_q <= cfg_wdata_i;
        CFG_GAIN:      gain_q     <= cfg_wdata_i;
        CFG_THRESHOLD: thr_q      <= cfg_wdata_i;
        CFG_MAX_STEP:  max_step_q <= cfg_wdata_i;
        CFG_PWM_TOP:   top_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fppl_avg #(
    .AVERAGE_DEPTH(AVERAGE_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (avg_ctrl),
    .sample_i(sample_q),
    .sum_o   (avg_sum),
    .fill_o  (avg_fill)
  );

  fppl_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_READ;
      ST_READ:      state_d = ST_SUM;
      ST_SUM:       state_d = ST_LVL_DIV;
      ST_LVL_DIV:   state_d = ST_LVL_WAIT;
      ST_LVL_WAIT:  if (div_done) state_d = ST_MUL;
      ST_MUL:       state_d = ST_STEP;
      ST_STEP:      state_d = ST_DUTY_DIV;
      ST_DUTY_DIV:  state_d = ST_DUTY_WAIT;
      ST_DUTY_WAIT: if (div_done) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    avg_ctrl     = '0;
    div_start    = 1'b0;
    div_dividend = DVD_W'(avg_sum);
    div_divisor  = DVS_W'(avg_fill);
    unique case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_READ:     avg_ctrl.rd = 1'b1;
      ST_SUM:      avg_ctrl.wr = 1'b1;
      ST_LVL_DIV:  div_start = 1'b1;
      ST_DUTY_DIV: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(duty_prod);
        div_divisor  = DVS_W'(top_q);
      end
      default: ;
    endcase
  end

  // error and gain product
  assign level_x = CMP_W'(level_q);
  assign acc_x   = CMP_W'(acc_q);
  assign set_x   = CMP_W'(setpoint_q);
  assign gap     = (level_x > acc_x) ? level_x - acc_x : acc_x - level_x;
  assign err     = (level_x > set_x) ? level_x - set_x : set_x - level_x;
  assign prod_d  = PROD_W'(err) * PROD_W'(gain_q);

  // clamped step and saturated compare update
  assign step_raw = prod_q[PROD_W-1:GAIN_FRAC];
  assign step_lim = (step_raw > STEP_W'(max_step_q)) ? max_step_q : step_raw[REG_W-1:0];
  assign cmp_up   = {1'b0, cmp_q} + {1'b0, step_lim};
  assign cmp_dn   = (cmp_q > step_lim) ? cmp_q - step_lim : '0;
  assign cmp_tmp  = neg_q ? {1'b0, cmp_dn} : cmp_up;
  assign cmp_next = (cmp_tmp > {1'b0, top_q}) ? top_q : cmp_tmp[REG_W-1:0];

  assign duty_prod = MUL_W'(cmp_q) * MUL_W'(DUTY_SCALE);
  always_comb begin
    if (top_q == '0) begin
      duty_d = '0;
    end else if (div_quo > DVD_W'(DUTY_SCALE)) begin
      duty_d = DUTY_SCALE;
    end else begin
      duty_d = div_quo[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= adc_sample_i;
    end
    if (state_q == ST_LVL_WAIT && div_done) begin
      level_q <= div_quo[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_MUL) begin
      adjust_q <= (gap > CMP_W'(thr_q));
      neg_q    <= (level_x > set_x);
      prod_q   <= prod_d;
    end
    if (state_q == ST_DUTY_WAIT && div_done) begin
      duty_q <= duty_d;
    end
    if (state_q == ST_DONE && out_free) begin
      filtered_level_q <= level_x[REG_W-1:0];
      adjusted_q       <= adjust_q;
      pwm_compare_q    <= cmp_q;
      duty_pct_q       <= duty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      cmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_STEP && adjust_q) begin
        cmp_q <= cmp_next;
        acc_q <= level_x[REG_W-1:0];
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_level_o = filtered_level_q;
  assign adjusted_o       = adjusted_q;
  assign pwm_compare_o    = pwm_compare_q;
  assign duty_pct_o       = duty_pct_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_LVL_WAIT || state_q == ST_DUTY_WAIT))
    else $error("divider finished outside a wait state");

  a_step_within_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && adjust_q) |=> (cmp_q <= top_q))
    else $error("compare value above pwm top after a step");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_free) |=> (state_q == ST_DONE && out_valid_q))
    else $error("item result left the done state while output busy");

endmodule

FILE: design/fppl_avg.sv
// ----------------------------------------------------------------------------
// fppl_avg - moving average ring
// sample ring memory with running sum, write slot and fill count
// ----------------------------------------------------------------------------
module fppl_avg #(
  parameter int unsigned AVERAGE_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS   = 10,
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(AVERAGE_DEPTH),
  localparam int unsigned CNT_W  = $clog2(AVERAGE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fppl_pkg::avg_ctrl_t  ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SUM_W-1:0]     sum_o,
  output logic [CNT_W-1:0]     fill_o
);
  import fppl_pkg::*;

  localparam int unsigned SLOT_W = $clog2(AVERAGE_DEPTH);

  logic [SAMPLE_BITS-1:0] mem [AVERAGE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic                   full;
  logic [SAMPLE_BITS-1:0] old_sample;

  // slots are written in order, so an entry is only stale once the ring is full
  assign full       = (fill_q == CNT_W'(AVERAGE_DEPTH));
  assign old_sample = full ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_q <= mem[slot_q];
    end
    if (ctrl_i.wr) begin
      mem[slot_q] <= sample_i;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    slot_d = slot_q;
    fill_d = fill_q;
    if (ctrl_i.wr) begin
      sum_d  = sum_q - SUM_W'(old_sample) + SUM_W'(sample_i);
      slot_d = (slot_q == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      fill_d = full ? fill_q : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      slot_q <= '0;
      fill_q <= '0;
    end else begin
      sum_q  <= sum_d;
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(AVERAGE_DEPTH))
    else $error("fill count beyond ring depth");

  a_slot_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != CNT_W'(AVERAGE_DEPTH)) |-> (CNT_W'(slot_q) == fill_q))
    else $error("write slot out of step with fill count");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr |-> $past(ctrl_i.rd))
    else $error("ring written without fetching the old sample");

endmodule

FILE: design/fppl_div.sv
// ----------------------------------------------------------------------------
// fppl_div - shared restoring divider
// one quotient bit per cycle, done pulses high for a single cycle as the last bit is registered
// ----------------------------------------------------------------------------
module fppl_div #(
  parameter int unsigned DVD_W = 17,
  parameter int unsigned DVS_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);
  import fppl_pkg::*;

  localparam int unsigned ITER_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ITER_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
